// ----- hdl/fbba_pkg.sv -----
package fbba_pkg;

   // Bitmap geometry. The store is kept as rows of eight bytes.
   localparam int MAX_BYTES     = 512;
   localparam int BYTES_PER_ROW = 8;
   localparam int ROWS          = MAX_BYTES / BYTES_PER_ROW;
   localparam int ROW_BITS      = BYTES_PER_ROW * 8;
   localparam int ROW_W         = $clog2(ROWS);
   localparam int ROWCNT_W      = $clog2(ROWS + 1);
   localparam int LANE_W        = $clog2(BYTES_PER_ROW);
   localparam int BIT_W         = 3;
   localparam int POS_W         = LANE_W + BIT_W;
   localparam int BYTE_W        = ROW_W + LANE_W;

   // Field widths.
   localparam int TYPE_W     = 3;
   localparam int NUM_W      = 24;
   localparam int START_W    = 9;
   localparam int SIZE_W     = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NUMBER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_IN_USE = 1'd1;
   localparam logic [SIZE_W-1:0]    SIZE_RESET       = SIZE_W'(MAX_BYTES);

   // Request codes.
   typedef enum logic [TYPE_W-1:0] {
      REQ_MARK_FREE = 3'd0,
      REQ_MARK_USED = 3'd1,
      REQ_ALL_FREE  = 3'd2,
      REQ_ALL_USED  = 3'd3,
      REQ_FIND      = 3'd4
   } req_code_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_SCAN,
      ST_RESULT
   } state_type;

   // Controls for evaluating one returned row during a scan.
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic              first;
      logic              last;
      logic [LANE_W-1:0] soff;
      logic [SIZE_W-1:0] size;
   } eval_ctl_type;

   // Outcome of evaluating one row.
   typedef struct packed {
      logic              hit;
      logic [LANE_W-1:0] lane;
      logic [BIT_W-1:0]  bit_pos;
   } eval_res_type;

endpackage

// ----- hdl/fbba_req_if.sv -----
interface fbba_req_if;
   logic                          valid;
   logic                          ready;
   logic [fbba_pkg::TYPE_W-1:0]   req_type;
   logic [fbba_pkg::NUM_W-1:0]    block_number;
   logic [fbba_pkg::START_W-1:0]  start_byte;

   modport source (output valid, output req_type, output block_number,
                   output start_byte, input ready);
   modport sink   (input valid, input req_type, input block_number,
                   input start_byte, output ready);
endinterface

// ----- hdl/fbba_rsp_if.sv -----
interface fbba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [fbba_pkg::NUM_W-1:0]    free_number;
   logic [fbba_pkg::START_W-1:0]  next_start_byte;
   logic                          error;

   modport source (output valid, output found, output free_number,
                   output next_start_byte, output error, input ready);
   modport sink   (input valid, input found, input free_number,
                   input next_start_byte, input error, output ready);
endinterface

// ----- hdl/fbba_ram.sv -----
module fbba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fbba_row_eval.sv -----
module fbba_row_eval (
   input  logic [fbba_pkg::ROW_BITS-1:0] row_data,
   input  fbba_pkg::eval_ctl_type        ctl,
   output fbba_pkg::eval_res_type        res
);

   logic [fbba_pkg::BYTES_PER_ROW-1:0] lane_hit;
   logic [7:0]                         sel_byte;

   // Qualify each byte lane: inside the size in use and inside the part of the
   // starting row that this visit covers, and holding at least one free bit.
   always_comb begin
      for (int j = 0; j < fbba_pkg::BYTES_PER_ROW; j++) begin
         lane_hit[j] =
            (fbba_pkg::SIZE_W'({ctl.row, fbba_pkg::LANE_W'(j)}) < ctl.size) &&
            (!ctl.first || (fbba_pkg::LANE_W'(j) >= ctl.soff)) &&
            (!ctl.last  || (fbba_pkg::LANE_W'(j) <  ctl.soff)) &&
            (row_data[j*8 +: 8] != 8'd0);
      end
   end

   // Lowest qualifying lane, then the lowest set bit inside it.
   always_comb begin
      res = '0;
      for (int j = fbba_pkg::BYTES_PER_ROW - 1; j >= 0; j--) begin
         if (lane_hit[j]) begin
            res.hit  = 1'b1;
            res.lane = fbba_pkg::LANE_W'(j);
         end
      end
      sel_byte = row_data[res.lane*8 +: 8];
      for (int k = 7; k >= 0; k--) begin
         if (sel_byte[k]) begin
            res.bit_pos = fbba_pkg::BIT_W'(k);
         end
      end
   end

endmodule

// ----- hdl/free_block_bitmap_allocator_top.sv -----
// Free-block bitmap allocator: a 512-byte bitmap (1 = free), all free after
// reset, held in a RAM of 64 rows of eight bytes with a valid bit per row so
// that reset needs no clearing pass. One request is worked on at a time and
// ready stays low until its result has moved into the output register; a
// finished result may wait there while the next request is taken. Marking one
// block reads, modifies and writes one row and then moves to the result
// state. Marking all blocks reads and writes back each row in use in turn. A
// find reads one row of eight bytes per cycle through a single row evaluator
// and the RAM's registered read port, visiting the rows from the start row
// onward and wrapping round. A request with an out-of-range block number or
// an unknown code goes straight to the result state.
module free_block_bitmap_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   fbba_req_if.sink                         req_bus,
   fbba_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [fbba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbba_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fbba_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [fbba_pkg::NUM_W-1:0]  base_ff;
   logic [fbba_pkg::SIZE_W-1:0] size_cfg_ff;

   // Sequencer datapath registers.
   logic                          op_set_ff;
   logic [fbba_pkg::POS_W-1:0]    blk_pos_ff;
   logic [fbba_pkg::ROW_W-1:0]    row_ff;
   logic [fbba_pkg::ROWCNT_W-1:0] cnt_ff;
   logic [fbba_pkg::LANE_W-1:0]   soff_ff;
   logic                          pend_ff;
   logic [fbba_pkg::ROW_W-1:0]    pend_row_ff;
   logic                          pend_first_ff;
   logic                          pend_last_ff;
   logic                          rd_valid_ff;
   logic [fbba_pkg::ROWS-1:0]     row_valid_ff;

   // Staged result and output register.
   logic                          res_found_ff;
   logic [fbba_pkg::NUM_W-1:0]    res_num_ff;
   logic [fbba_pkg::START_W-1:0]  res_where_ff;
   logic                          res_err_ff;
   logic                          rsp_valid_ff;
   logic                          out_found_ff;
   logic [fbba_pkg::NUM_W-1:0]    out_num_ff;
   logic [fbba_pkg::START_W-1:0]  out_where_ff;
   logic                          out_err_ff;

   // Combinational signals.
   logic [fbba_pkg::SIZE_W-1:0]   size_now;
   logic [fbba_pkg::SIZE_W-1:0]   size_round;
   logic [fbba_pkg::ROWCNT_W-1:0] rows_used;
   logic [fbba_pkg::ROWCNT_W-1:0] row_plus;
   logic                          row_is_last;
   logic                          req_accept;
   logic [fbba_pkg::NUM_W-1:0]    offs;
   logic                          out_of_range;
   logic [fbba_pkg::START_W-1:0]  start_eff;
   logic                          issue_more;
   logic                          scan_done;
   logic                          out_free;
   logic                          ram_wr_en;
   logic [fbba_pkg::ROW_BITS-1:0] ram_rd_data;
   logic [fbba_pkg::ROW_BITS-1:0] cur_row;
   logic [fbba_pkg::ROW_BITS-1:0] mark_data;
   logic [fbba_pkg::ROW_BITS-1:0] fill_data;
   logic [fbba_pkg::ROW_BITS-1:0] ram_wr_data;
   fbba_pkg::eval_ctl_type        ev_ctl;
   fbba_pkg::eval_res_type        ev_res;

   // Size in use and the number of rows it covers.
   assign size_now   = (size_cfg_ff > fbba_pkg::SIZE_RESET) ? fbba_pkg::SIZE_RESET
                                                            : size_cfg_ff;
   assign size_round = size_now + fbba_pkg::SIZE_W'(fbba_pkg::BYTES_PER_ROW - 1);
   assign rows_used  = fbba_pkg::ROWCNT_W'(size_round >> fbba_pkg::LANE_W);
   assign row_plus   = fbba_pkg::ROWCNT_W'(row_ff) + fbba_pkg::ROWCNT_W'(1);
   assign row_is_last = (row_plus == rows_used);

   // Request decode terms.
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign offs         = req_bus.block_number - base_ff;
   assign out_of_range = (req_bus.block_number < base_ff) ||
                         (offs[fbba_pkg::NUM_W-1:fbba_pkg::BIT_W] >=
                          (fbba_pkg::NUM_W - fbba_pkg::BIT_W)'(size_now));
   assign start_eff    = (fbba_pkg::SIZE_W'(req_bus.start_byte) >= size_now) ?
                         '0 : req_bus.start_byte;

   // Scan bookkeeping: visits 0 to rows_used, the last one revisits the start row.
   assign issue_more = (cnt_ff <= rows_used);
   assign scan_done  = pend_ff && (ev_res.hit || !issue_more);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Row memory.
   fbba_ram #(
      .WIDTH (fbba_pkg::ROW_BITS),
      .DEPTH (fbba_pkg::ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (ram_wr_data),
      .rd_addr (row_ff),
      .rd_data (ram_rd_data)
   );

   // A row never written since reset reads as all free.
   assign cur_row = rd_valid_ff ? ram_rd_data : '1;

   // Single-bit update for a mark request.
   always_comb begin
      mark_data             = cur_row;
      mark_data[blk_pos_ff] = op_set_ff;
   end

   // Whole-row fill, leaving bytes beyond the size in use untouched.
   always_comb begin
      for (int j = 0; j < fbba_pkg::BYTES_PER_ROW; j++) begin
         if (fbba_pkg::SIZE_W'({row_ff, fbba_pkg::LANE_W'(j)}) < size_now) begin
            fill_data[j*8 +: 8] = {8{op_set_ff}};
         end else begin
            fill_data[j*8 +: 8] = cur_row[j*8 +: 8];
         end
      end
   end

   assign ram_wr_data = (state_ff == fbba_pkg::ST_MARK_WR) ? mark_data : fill_data;

   // Row evaluator for the scan.
   assign ev_ctl.row   = pend_row_ff;
   assign ev_ctl.first = pend_first_ff;
   assign ev_ctl.last  = pend_last_ff;
   assign ev_ctl.soff  = soff_ff;
   assign ev_ctl.size  = size_now;

   fbba_row_eval u_eval (
      .row_data (cur_row),
      .ctl      (ev_ctl),
      .res      (ev_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbba_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (fbba_pkg::req_code_type'(req_bus.req_type)) inside
                  fbba_pkg::REQ_MARK_FREE, fbba_pkg::REQ_MARK_USED: begin
                     state_in = out_of_range ? fbba_pkg::ST_RESULT
                                             : fbba_pkg::ST_MARK_RD;
                  end
                  fbba_pkg::REQ_ALL_FREE, fbba_pkg::REQ_ALL_USED: begin
                     state_in = (rows_used == '0) ? fbba_pkg::ST_RESULT
                                                  : fbba_pkg::ST_FILL_RD;
                  end
                  fbba_pkg::REQ_FIND: begin
                     state_in = (rows_used == '0) ? fbba_pkg::ST_RESULT
                                                  : fbba_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = fbba_pkg::ST_RESULT;
                  end
               endcase
            end
         end
         fbba_pkg::ST_MARK_RD: state_in = fbba_pkg::ST_MARK_WR;
         fbba_pkg::ST_MARK_WR: state_in = fbba_pkg::ST_RESULT;
         fbba_pkg::ST_FILL_RD: state_in = fbba_pkg::ST_FILL_WR;
         fbba_pkg::ST_FILL_WR: begin
            state_in = row_is_last ? fbba_pkg::ST_RESULT : fbba_pkg::ST_FILL_RD;
         end
         fbba_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = fbba_pkg::ST_RESULT;
            end
         end
         fbba_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = fbba_pkg::ST_IDLE;
            end
         end
         default: state_in = fbba_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      ram_wr_en     = 1'b0;
      unique case (state_ff)
         fbba_pkg::ST_IDLE:    req_bus.ready = 1'b1;
         fbba_pkg::ST_MARK_WR: ram_wr_en     = 1'b1;
         fbba_pkg::ST_FILL_WR: ram_wr_en     = 1'b1;
         default: begin
            req_bus.ready = 1'b0;
            ram_wr_en     = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbba_pkg::ST_IDLE;
         base_ff      <= '0;
         size_cfg_ff  <= fbba_pkg::SIZE_RESET;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && (csr_index == fbba_pkg::CSR_BASE_NUMBER)) begin
            base_ff <= csr_wdata[fbba_pkg::NUM_W-1:0];
         end
         if (csr_wr_en && (csr_index == fbba_pkg::CSR_BYTES_IN_USE)) begin
            size_cfg_ff <= csr_wdata[fbba_pkg::SIZE_W-1:0];
         end
         if (ram_wr_en) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
         if (state_ff == fbba_pkg::ST_SCAN) begin
            pend_ff <= issue_more && !scan_done;
         end else begin
            pend_ff <= 1'b0;
         end
         if ((state_ff == fbba_pkg::ST_RESULT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Valid bit that travels with the registered RAM read.
   always_ff @(posedge clock) begin
      rd_valid_ff <= row_valid_ff[row_ff];
   end

   // Sequencer datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         fbba_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_set_ff    <= (req_bus.req_type == fbba_pkg::REQ_MARK_FREE) ||
                               (req_bus.req_type == fbba_pkg::REQ_ALL_FREE);
               blk_pos_ff   <= offs[fbba_pkg::POS_W-1:0];
               cnt_ff       <= '0;
               soff_ff      <= start_eff[fbba_pkg::LANE_W-1:0];
               res_found_ff <= 1'b0;
               res_num_ff   <= '0;
               res_where_ff <= '0;
               res_err_ff   <= 1'b0;
               case (fbba_pkg::req_code_type'(req_bus.req_type)) inside
                  fbba_pkg::REQ_MARK_FREE, fbba_pkg::REQ_MARK_USED: begin
                     row_ff     <= offs[fbba_pkg::ROW_W+fbba_pkg::POS_W-1:fbba_pkg::POS_W];
                     res_err_ff <= out_of_range;
                  end
                  fbba_pkg::REQ_FIND: begin
                     row_ff <= start_eff[fbba_pkg::START_W-1:fbba_pkg::LANE_W];
                  end
                  default: begin
                     row_ff <= '0;
                  end
               endcase
            end
         end
         fbba_pkg::ST_FILL_WR: begin
            row_ff <= row_plus[fbba_pkg::ROW_W-1:0];
         end
         fbba_pkg::ST_SCAN: begin
            // Issue the next row read while the previous row is evaluated.
            pend_row_ff   <= row_ff;
            pend_first_ff <= (cnt_ff == '0);
            pend_last_ff  <= (cnt_ff == rows_used);
            row_ff        <= row_is_last ? '0 : row_plus[fbba_pkg::ROW_W-1:0];
            cnt_ff        <= cnt_ff + fbba_pkg::ROWCNT_W'(1);
            if (pend_ff && ev_res.hit) begin
               res_found_ff <= 1'b1;
               res_num_ff   <= base_ff + fbba_pkg::NUM_W'({pend_row_ff, ev_res.lane,
                                                           ev_res.bit_pos});
               res_where_ff <= fbba_pkg::START_W'({pend_row_ff, ev_res.lane});
            end
         end
         default: begin
            row_ff <= row_ff;
         end
      endcase
   end

   // Output register loads when the previous beat has left.
   always_ff @(posedge clock) begin
      if ((state_ff == fbba_pkg::ST_RESULT) && out_free) begin
         out_found_ff <= res_found_ff;
         out_num_ff   <= res_num_ff;
         out_where_ff <= res_where_ff;
         out_err_ff   <= res_err_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.found           = out_found_ff;
   assign rsp_bus.free_number     = out_num_ff;
   assign rsp_bus.next_start_byte = out_where_ff;
   assign rsp_bus.error           = out_err_ff;

endmodule

// ----- hdl/fbba_checker.sv -----
module fbba_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            found,
   input logic [fbba_pkg::NUM_W-1:0]      free_number,
   input logic [fbba_pkg::START_W-1:0]    next_start_byte,
   input logic                            error
);

   // One request at a time: an accepted beat closes the input side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted again right after an accepted beat");

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // A result beat never flags both found and error.
   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(found && error))
      else $error("result flags both found and error");

   // When nothing was found the number and byte fields are zero.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !found) |-> ((free_number == '0) && (next_start_byte == '0)))
      else $error("result fields not zero without a found block");

endmodule

bind free_block_bitmap_allocator_top fbba_checker u_fbba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .found           (rsp_bus.found),
   .free_number     (rsp_bus.free_number),
   .next_start_byte (rsp_bus.next_start_byte),
   .error           (rsp_bus.error)
);

// ----- dv/free_block_bitmap_allocator_top_tb.sv -----
module free_block_bitmap_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One response beat as the allocator should return it.
   typedef struct packed {
      logic                          found;
      logic [fbba_pkg::NUM_W-1:0]    free_number;
      logic [fbba_pkg::START_W-1:0]  next_start_byte;
      logic                          error;
   } alloc_result_type;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned ITEM_TARGET   = 1450;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned TAIL_CYCLES   = 80;

   // Request codes that the allocator does not define.
   localparam logic [fbba_pkg::TYPE_W-1:0] REQ_FIRST_UNKNOWN =
      fbba_pkg::TYPE_W'(fbba_pkg::REQ_FIND + 1);
   localparam logic [fbba_pkg::TYPE_W-1:0] REQ_LAST_UNKNOWN  = '1;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [fbba_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fbba_pkg::CSR_DATA_W-1:0] csr_wdata;

   fbba_req_if req_bus ();
   fbba_rsp_if rsp_bus ();

   free_block_bitmap_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the bitmap and the two registers.
   logic [7:0]                  free_shadow [fbba_pkg::MAX_BYTES];
   logic [fbba_pkg::NUM_W-1:0]  base_shadow;
   logic [fbba_pkg::SIZE_W-1:0] size_shadow;

   alloc_result_type expected_results [$];

   int unsigned error_count    = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned hits_seen      = 0;
   int unsigned range_flags    = 0;
   int unsigned settings_used  = 0;
   int unsigned cycle_count    = 0;
   int unsigned burst_left     = 0;
   int unsigned stall_tick     = 0;
   int unsigned stall_mode     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Number of bitmap bytes that the current size register covers.
   function automatic int unsigned bytes_scanned();
      return (size_shadow > fbba_pkg::MAX_BYTES) ? fbba_pkg::MAX_BYTES : int'(size_shadow);
   endfunction

   // Applies one request to the shadow bitmap and returns the response it causes.
   function automatic alloc_result_type predict_allocation(
      input logic [fbba_pkg::TYPE_W-1:0]  code,
      input logic [fbba_pkg::NUM_W-1:0]   blk,
      input logic [fbba_pkg::START_W-1:0] start);
      alloc_result_type           res;
      int unsigned                size;
      logic [fbba_pkg::NUM_W-1:0] offset;
      int unsigned                pos;
      int unsigned                idx;
      int                         low;
      res  = '0;
      size = bytes_scanned();
      case (code) inside
         fbba_pkg::REQ_MARK_FREE, fbba_pkg::REQ_MARK_USED: begin
            offset = blk - base_shadow;
            if (blk < base_shadow || (offset >> 3) >= size) begin
               res.error = 1'b1;
            end else begin
               free_shadow[offset >> 3][offset[2:0]] = (code == fbba_pkg::REQ_MARK_FREE);
            end
         end
         fbba_pkg::REQ_ALL_FREE, fbba_pkg::REQ_ALL_USED: begin
            for (int i = 0; i < size; i++)
               free_shadow[i] = (code == fbba_pkg::REQ_ALL_FREE) ? 8'hFF : 8'h00;
         end
         fbba_pkg::REQ_FIND: begin
            pos = (start >= size) ? 0 : start;
            for (int n = 0; n < size && !res.found; n++) begin
               idx = pos + n;
               if (idx >= size)
                  idx -= size;
               if (free_shadow[idx] != 8'h00) begin
                  low = 0;
                  for (int k = 7; k >= 0; k--)
                     if (free_shadow[idx][k])
                        low = k;
                  res.found           = 1'b1;
                  res.free_number     = fbba_pkg::NUM_W'(base_shadow + idx * 8 + low);
                  res.next_start_byte = fbba_pkg::START_W'(idx);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Sends one request beat, idling between bursts, and records the response it expects.
   task automatic send_request(input logic [fbba_pkg::TYPE_W-1:0]  code,
                               input logic [fbba_pkg::NUM_W-1:0]   blk,
                               input logic [fbba_pkg::START_W-1:0] start);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= code;
      req_bus.block_number <= blk;
      req_bus.start_byte   <= start;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_allocation(code, blk, start));
      burst_left--;
      items_accepted++;
   endtask

   // Holds the request side until every outstanding response has come back.
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back; the block must be idle.
   task automatic write_config(input logic [fbba_pkg::NUM_W-1:0]      base,
                               input logic [fbba_pkg::CSR_DATA_W-1:0] size_word);
      csr_wr_en <= 1'b1;
      csr_index <= fbba_pkg::CSR_BASE_NUMBER;
      csr_wdata <= base;
      @(posedge clock);
      base_shadow = base;
      csr_index <= fbba_pkg::CSR_BYTES_IN_USE;
      csr_wdata <= size_word;
      @(posedge clock);
      size_shadow = size_word[fbba_pkg::SIZE_W-1:0];
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
      error_count++;
   endtask

   // Reset contents: everything free, base 0, full size.
   task automatic test_reset_state();
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'd0);
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'h1FF);
      send_request(fbba_pkg::REQ_MARK_USED, 24'd0, fbba_pkg::START_W'($urandom));
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'd0);
   endtask

   // Whole-map operations, wraparound and range checks at full size.
   task automatic test_full_map();
      send_request(fbba_pkg::REQ_ALL_USED, fbba_pkg::NUM_W'($urandom),
                   fbba_pkg::START_W'($urandom));
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'd0);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'd4095, 9'd0);
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'd0);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'd0, 9'd0);
      send_request(fbba_pkg::REQ_FIND, fbba_pkg::NUM_W'($urandom), 9'd300);
      send_request(fbba_pkg::REQ_MARK_USED, 24'd4096, 9'd0);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'hFFFFFF, 9'h1FF);
      send_request(REQ_FIRST_UNKNOWN, fbba_pkg::NUM_W'($urandom),
                   fbba_pkg::START_W'($urandom));
      send_request(REQ_LAST_UNKNOWN, 24'hFFFFFF, 9'h1FF);
      send_request(fbba_pkg::REQ_ALL_FREE, 24'd0, 9'd0);
   endtask

   // A high base, a start byte beyond the size, and blocks just outside the map.
   task automatic test_high_base();
      wait_for_idle();
      write_config(24'hFFF000, 24'd8);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'hFFEFFF, 9'd0);
      send_request(fbba_pkg::REQ_ALL_USED, 24'd0, 9'd0);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'hFFF03F, 9'd0);
      send_request(fbba_pkg::REQ_FIND, 24'd0, 9'h1FF);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'hFFF040, 9'd0);
   endtask

   // Block numbers that wrap past the top of the 24-bit range.
   task automatic test_number_wrap();
      wait_for_idle();
      write_config(24'hFFFFF8, 24'd2);
      send_request(fbba_pkg::REQ_ALL_FREE, 24'd0, 9'd0);
      send_request(fbba_pkg::REQ_FIND, 24'd0, 9'd1);
      send_request(fbba_pkg::REQ_MARK_USED, 24'hFFFFFF, 9'd0);
   endtask

   // Empty map, oversized size register, and bytes left alone beyond the size.
   task automatic test_size_edges();
      wait_for_idle();
      write_config(24'd0, 24'd0);
      send_request(fbba_pkg::REQ_MARK_FREE, 24'd0, 9'd0);
      send_request(fbba_pkg::REQ_ALL_FREE, 24'd0, 9'd0);
      send_request(fbba_pkg::REQ_FIND, 24'd0, 9'd0);
      wait_for_idle();
      write_config(24'd0, 24'h0003FF);
      send_request(fbba_pkg::REQ_FIND, 24'd0, 9'h1FF);
      wait_for_idle();
      write_config(24'd0, 24'd8);
      send_request(fbba_pkg::REQ_ALL_USED, 24'd0, 9'd0);
      wait_for_idle();
      write_config(24'd0, 24'd16);
      send_request(fbba_pkg::REQ_FIND, 24'd0, 9'd0);
   endtask

   // Random phases: each picks a setting, shapes the map, then mixes requests.
   task automatic test_random_traffic();
      int unsigned                     size;
      int unsigned                     scanned;
      int unsigned                     pick;
      int unsigned                     phase_len;
      logic [fbba_pkg::NUM_W-1:0]      base;
      logic [fbba_pkg::CSR_DATA_W-1:0] size_word;
      logic [fbba_pkg::NUM_W-1:0]      blk;
      logic [fbba_pkg::START_W-1:0]    start;
      logic [fbba_pkg::TYPE_W-1:0]     code;
      while (items_accepted < ITEM_TARGET) begin
         wait_for_idle();
         pick = $urandom_range(0, 19);
         if (pick == 0)
            size = 0;
         else if (pick == 1)
            size = fbba_pkg::MAX_BYTES;
         else if (pick == 2)
            size = $urandom_range(fbba_pkg::MAX_BYTES + 1, (1 << fbba_pkg::SIZE_W) - 1);
         else if (pick < 5)
            size = $urandom_range(65, fbba_pkg::MAX_BYTES - 1);
         else
            size = $urandom_range(1, 64);
         pick = $urandom_range(0, 9);
         if (pick == 0)
            base = '0;
         else if (pick == 1)
            base = 24'hFFF000;
         else if (pick == 2)
            base = '1;
         else
            base = fbba_pkg::NUM_W'($urandom);
         size_word = fbba_pkg::CSR_DATA_W'($urandom);
         size_word[fbba_pkg::SIZE_W-1:0] = fbba_pkg::SIZE_W'(size);
         write_config(base, size_word);
         scanned = bytes_scanned();

         // Most phases start from a full or an empty map.
         pick = $urandom_range(0, 9);
         if (pick < 5)
            send_request(fbba_pkg::REQ_ALL_USED, fbba_pkg::NUM_W'($urandom),
                         fbba_pkg::START_W'($urandom));
         else if (pick < 7)
            send_request(fbba_pkg::REQ_ALL_FREE, fbba_pkg::NUM_W'($urandom),
                         fbba_pkg::START_W'($urandom));

         phase_len = $urandom_range(30, 80);
         repeat (phase_len) begin
            pick  = $urandom_range(0, 99);
            blk   = fbba_pkg::NUM_W'($urandom);
            start = fbba_pkg::START_W'($urandom);
            if (scanned != 0 && pick < 50)
               blk = fbba_pkg::NUM_W'(base_shadow + $urandom_range(0, scanned * 8 - 1));
            if (scanned != 0 && $urandom_range(0, 4) != 0)
               start = fbba_pkg::START_W'($urandom_range(0, scanned - 1));
            if (pick < 30)
               code = fbba_pkg::REQ_MARK_USED;
            else if (pick < 50)
               code = fbba_pkg::REQ_MARK_FREE;
            else if (pick < 75)
               code = fbba_pkg::REQ_FIND;
            else if (pick < 79)
               code = fbba_pkg::REQ_ALL_USED;
            else if (pick < 82)
               code = fbba_pkg::REQ_ALL_FREE;
            else if (pick < 92)
               code = $urandom_range(0, 1) ? fbba_pkg::REQ_MARK_USED
                                           : fbba_pkg::REQ_MARK_FREE;
            else
               code = fbba_pkg::TYPE_W'($urandom_range(REQ_FIRST_UNKNOWN, REQ_LAST_UNKNOWN));
            send_request(code, blk, start);
         end
      end
   endtask

   // Response side: stall pattern and per-beat comparison.
   always @(posedge clock) begin
      alloc_result_type want;
      stall_tick++;
      if (stall_tick % 150 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= (stall_tick % 4 == 0);
      endcase
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %0h %0h %0h %0h",
                     $realtime, rsp_bus.found, rsp_bus.free_number,
                     rsp_bus.next_start_byte, rsp_bus.error);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.found !== want.found)
               report_mismatch("found", 32'(want.found), 32'(rsp_bus.found));
            if (rsp_bus.free_number !== want.free_number)
               report_mismatch("free_number", 32'(want.free_number),
                               32'(rsp_bus.free_number));
            if (rsp_bus.next_start_byte !== want.next_start_byte)
               report_mismatch("next_start_byte", 32'(want.next_start_byte),
                               32'(rsp_bus.next_start_byte));
            if (rsp_bus.error !== want.error)
               report_mismatch("error", 32'(want.error), 32'(rsp_bus.error));
            if (want.found)
               hits_seen++;
            if (want.error)
               range_flags++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= fbba_pkg::CSR_BASE_NUMBER;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= fbba_pkg::REQ_MARK_FREE;
      req_bus.block_number <= '0;
      req_bus.start_byte   <= '0;
      base_shadow = '0;
      size_shadow = fbba_pkg::SIZE_RESET;
      for (int i = 0; i < fbba_pkg::MAX_BYTES; i++)
         free_shadow[i] = 8'hFF;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_full_map();
      test_high_base();
      test_number_wrap();
      test_size_edges();
      test_random_traffic();

      wait_for_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests across %0d register settings; %0d responses checked.",
               items_accepted, settings_used, results_seen);
      $display("Finds that located a block: %0d, out-of-range marks: %0d, mismatches: %0d.",
               hits_seen, range_flags, error_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
